### hdl/sha_pkg.sv
// sha-256 engine package: shared types, constants and round functions
// used by the top level, the round datapath and the checker; no dependencies
`timescale 1ns / 1ps

package sha_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,     // waiting for a beat
    ST_LOAD,     // load working vars from chain memory
    ST_ROUND,    // 64 rounds
    ST_UPDATE,   // add working vars into chain memory
    ST_PAD,      // write padding bytes into the block buffer
    ST_EMIT,     // read chain word
    ST_OUT,      // hold digest word until taken
    ST_INIT      // rewrite initial hash values
  } state_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### hdl/sha256_hash_engine.sv
// sha-256 engine top level: control sequencer, block, schedule and chain memories
// depends on sha_pkg, sha_ram, sha_round
//
// One byte per beat. A data beat is written to the block buffer memory and the
// next beat can follow on the next cycle. The 64th byte starts a compression
// with the input stalled: the working words are loaded from the chain memory,
// then 64 rounds run (four byte reads or four window reads per round) and the
// working words are added back into the chain memory one word at a time. No
// new byte is taken until the compression completes. A finish beat pads the
// buffer and runs one compression, or two when fewer than eight bytes are free
// after the 0x80 (padding again before the second). Each of the eight digest
// beats is then read from the chain memory and held until taken, and the
// initial hash values are rewritten before the next beat is taken.
`timescale 1ns / 1ps

module sha256_hash_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::out_beat_t out_data
);

  sha_pkg::state_t state, state_next;

  logic [5:0]  fill_count;
  logic [63:0] byte_count;
  logic        finishing, second;   // in finish; another block follows
  logic [6:0]  cnt;                 // general step counter
  logic [5:0]  round;
  logic [1:0]  sub;                 // sub-step within a round
  logic [31:0] wacc;                // byte gather accumulator
  logic [31:0] w15, w2, w7;
  logic        init_done;
  logic        rnd_fire;            // round step, in the cycle after the last read
  logic [5:0]  prev_round;          // round that rnd_fire belongs to

  // block buffer memory
  logic       bb_we;
  logic [5:0] bb_wa, bb_ra;
  logic [7:0] bb_wd, bb_rd;
  sha_ram #(.Width(8), .Depth(64)) u_block (
    .clk(clk), .wr_en(bb_we), .wr_addr(bb_wa), .wr_data(bb_wd),
    .rd_addr(bb_ra), .rd_data(bb_rd));

  // schedule window memory
  logic        sw_we;
  logic [3:0]  sw_wa, sw_ra;
  logic [31:0] sw_wd, sw_rd;
  sha_ram #(.Width(32), .Depth(16)) u_sched (
    .clk(clk), .wr_en(sw_we), .wr_addr(sw_wa), .wr_data(sw_wd),
    .rd_addr(sw_ra), .rd_data(sw_rd));

  // chain value memory
  logic        cv_we;
  logic [2:0]  cv_wa, cv_ra;
  logic [31:0] cv_wd, cv_rd;
  sha_ram #(.Width(32), .Depth(8)) u_chain (
    .clk(clk), .wr_en(cv_we), .wr_addr(cv_wa), .wr_data(cv_wd),
    .rd_addr(cv_ra), .rd_data(cv_rd));

  // round datapath
  logic        rl_load, rl_step;
  logic [2:0]  rl_idx, rl_ridx;
  logic [31:0] rl_w, rl_rd;
  sha_round u_round (
    .clk(clk), .load(rl_load), .load_idx(rl_idx), .load_word(cv_rd),
    .step(rl_step), .round(prev_round), .w(rl_w), .rd_idx(rl_ridx), .rd_word(rl_rd));

  logic in_acc, out_acc;
  assign in_stall  = (state != sha_pkg::ST_IDLE) || !init_done;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state == sha_pkg::ST_OUT);
  assign out_acc   = out_valid && !out_stall;

  logic [63:0] bits;
  assign bits = {byte_count[60:0], 3'b000};

  // padding byte for buffer position cnt
  logic [7:0] pad_byte;
  always_comb begin
    if (!second && cnt[5:0] >= 6'd56) begin
      pad_byte = bits[6'(63 - 8 * cnt[2:0]) -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == sha_pkg::CMD_FINISH) state_next = sha_pkg::ST_PAD;
          else if (fill_count == 6'd63) state_next = sha_pkg::ST_LOAD;
        end
      end
      sha_pkg::ST_PAD:    if (cnt == 7'd64) state_next = sha_pkg::ST_LOAD;
      sha_pkg::ST_LOAD:   if (cnt == 7'd8) state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND:  if (round == 6'd63 && sub == 2'd3) state_next = sha_pkg::ST_UPDATE;
      sha_pkg::ST_UPDATE: begin
        if (cnt == 7'd8) begin
          if (!finishing) state_next = sha_pkg::ST_IDLE;
          else if (second) state_next = sha_pkg::ST_PAD;
          else state_next = sha_pkg::ST_EMIT;
        end
      end
      sha_pkg::ST_EMIT:   state_next = sha_pkg::ST_OUT;
      sha_pkg::ST_OUT: begin
        if (out_acc) state_next = (cnt[2:0] == 3'd7) ? sha_pkg::ST_INIT : sha_pkg::ST_EMIT;
      end
      sha_pkg::ST_INIT:   if (cnt == 7'd7) state_next = sha_pkg::ST_IDLE;
      default:            state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // schedule word from window reads w15,w2,w7 and current sw_rd (w16)
  logic [31:0] s0, s1, wsched;
  always_comb begin
    s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    wsched = s1 + w7 + s0 + sw_rd;
  end

  // memory and datapath controls
  // round sub-steps, r<16: sub0..3 read bytes, the fourth byte arrives next cycle
  // r>=16: sub0 read r-15, sub1 read r-2, sub2 read r-7, sub3 read r, then compute
  always_comb begin
    bb_we = 1'b0; bb_wa = fill_count; bb_wd = in_data.data_byte; bb_ra = '0;
    sw_we = 1'b0; sw_wa = round[3:0]; sw_wd = '0; sw_ra = '0;
    cv_we = 1'b0; cv_wa = cnt[2:0]; cv_wd = '0; cv_ra = cnt[2:0];
    rl_load = 1'b0; rl_step = 1'b0; rl_idx = 3'(cnt - 7'd1); rl_w = '0;
    rl_ridx = cnt[2:0];
    unique case (state)
      sha_pkg::ST_IDLE: begin
        bb_we = in_acc && (in_data.command == sha_pkg::CMD_ABSORB);
        if (in_acc && in_data.command == sha_pkg::CMD_FINISH) begin
          bb_we = 1'b1; bb_wd = 8'h80;
        end
      end
      sha_pkg::ST_PAD: begin
        // nothing to pad in the first block when the 0x80 took its last byte
        bb_we = (cnt < 7'd64) && (cnt[5:0] >= fill_count) &&
                !(second && fill_count == 6'd0);
        bb_wa = cnt[5:0]; bb_wd = pad_byte;
      end
      sha_pkg::ST_LOAD: begin
        rl_load = (cnt != 7'd0);
      end
      sha_pkg::ST_ROUND: begin
        if (round < 6'd16) begin
          bb_ra = {round[3:0], sub};
        end else begin
          unique case (sub)
            2'd0: sw_ra = 4'(round - 6'd15);
            2'd1: sw_ra = 4'(round - 6'd2);
            2'd2: sw_ra = 4'(round - 6'd7);
            default: sw_ra = round[3:0];
          endcase
        end
      end
      sha_pkg::ST_UPDATE: begin
        cv_we = (cnt != 7'd0) && (cnt < 7'd9);
        cv_wa = 3'(cnt - 7'd1);
        rl_ridx = 3'(cnt - 7'd1);
        cv_wd = cv_rd + rl_rd;
      end
      sha_pkg::ST_EMIT: ;
      sha_pkg::ST_OUT: begin
        cv_ra = 3'(cnt + 7'd1);
      end
      sha_pkg::ST_INIT: begin
        cv_we = 1'b1; cv_wd = sha_pkg::init_hash(cnt[2:0]);
      end
      default: ;
    endcase
    // round step and window write-back on the cycle after the last read
    if (rnd_fire) begin
      rl_step = 1'b1;
      rl_w = (prev_round >= 6'd16) ? wsched : {wacc[23:0], bb_rd};
      sw_we = 1'b1; sw_wa = prev_round[3:0]; sw_wd = rl_w;
    end
  end

  // round fire flag: tail step after gathering / reading
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_fire <= 1'b0;
    end else begin
      rnd_fire <= (state == sha_pkg::ST_ROUND) && (sub == 2'd3);
    end
  end

  // round number seen by the tail step
  always_ff @(posedge clk) begin
    prev_round <= round;
  end

  // sequential control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha_pkg::ST_INIT;
      fill_count <= '0;
      byte_count <= '0;
      finishing  <= 1'b0;
      second     <= 1'b0;
      cnt        <= '0;
      round      <= '0;
      sub        <= '0;
      init_done  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        sha_pkg::ST_IDLE: begin
          cnt <= '0; round <= '0; sub <= '0;
          if (in_acc) begin
            if (in_data.command == sha_pkg::CMD_ABSORB) begin
              fill_count <= fill_count + 6'd1;
              byte_count <= byte_count + 64'd1;
            end else begin
              finishing <= 1'b1;
              second    <= (fill_count >= 6'd56);
              fill_count <= fill_count + 6'd1;
            end
          end
        end
        sha_pkg::ST_PAD: begin
          cnt <= (cnt == 7'd64) ? 7'd0 : cnt + 7'd1;
          if (cnt == 7'd64) begin
            round <= '0; sub <= '0;
          end
        end
        sha_pkg::ST_LOAD: begin
          cnt <= (cnt == 7'd8) ? 7'd0 : cnt + 7'd1;
        end
        sha_pkg::ST_ROUND: begin
          sub <= sub + 2'd1;
          if (sub == 2'd3) round <= round + 6'd1;
          if (round == 6'd63 && sub == 2'd3) cnt <= '0;
        end
        sha_pkg::ST_UPDATE: begin
          cnt <= (cnt == 7'd8) ? 7'd0 : cnt + 7'd1;
          if (cnt == 7'd8 && finishing && second) begin
            second     <= 1'b0;
            fill_count <= '0;
          end
        end
        sha_pkg::ST_EMIT: ;
        sha_pkg::ST_OUT: begin
          if (out_acc) cnt <= (cnt[2:0] == 3'd7) ? 7'd0 : cnt + 7'd1;
        end
        sha_pkg::ST_INIT: begin
          cnt <= (cnt == 7'd7) ? 7'd0 : cnt + 7'd1;
          if (cnt == 7'd7) begin
            init_done  <= 1'b1;
            finishing  <= 1'b0;
            fill_count <= '0;
            byte_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // byte gather and schedule operand capture
  always_ff @(posedge clk) begin
    if (state == sha_pkg::ST_ROUND && round < 6'd16 && sub != 2'd0) begin
      wacc <= {wacc[23:0], bb_rd};
    end
    if (state == sha_pkg::ST_ROUND && round >= 6'd16) begin
      if (sub == 2'd1) w15 <= sw_rd;
      if (sub == 2'd2) w2  <= sw_rd;
      if (sub == 2'd3) w7  <= sw_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == sha_pkg::ST_EMIT) begin
      out_data.digest_word <= cv_rd;
      out_data.word_index  <= cnt[2:0];
      out_data.last_word   <= (cnt[2:0] == 3'd7);
    end
  end

endmodule

### hdl/sha_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/sha_round.sv
// sha-256 round datapath: eight working registers and one round per cycle while step is high
// depends on sha_pkg
`timescale 1ns / 1ps

module sha_round (
  input  logic        clk,
  input  logic        load,
  input  logic [2:0]  load_idx,
  input  logic [31:0] load_word,
  input  logic        step,
  input  logic [5:0]  round,
  input  logic [31:0] w,
  input  logic [2:0]  rd_idx,
  output logic [31:0] rd_word
);

  logic [31:0] v [8];
  logic [31:0] t1, t2, e, a;

  assign e = v[4];
  assign a = v[0];

  // round function
  always_comb begin
    t1 = v[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
       + ((e & v[5]) ^ (~e & v[6])) + sha_pkg::ROUND_K[round] + w;
    t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
       + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  // working registers: serial load by index, or one round
  always_ff @(posedge clk) begin
    if (load) begin
      v[load_idx] <= load_word;
    end else if (step) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign rd_word = v[rd_idx];

endmodule

### hdl/sha256_hash_engine_chk.sv
// port-level checker for the sha-256 engine, bound to the top level
// depends on sha_pkg
`timescale 1ns / 1ps

module sha256_hash_engine_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sha_pkg::out_beat_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // input is not taken while a digest is pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during digest output");

  // last word flag matches index seven
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last word flag mismatch");

  // after the last word is taken no result is shown next cycle
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last_word |=> !out_valid)
    else $error("result after last word");

endmodule

bind sha256_hash_engine sha256_hash_engine_chk u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
